/* sv/sccb_pkg.sv */
// ----------------------------------------------------------------------------
// sccb_pkg
// Shared types and codes for the two-wire bit-level master sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package sccb_pkg;

  localparam int unsigned ActionW = 3;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CountW  = 4;
  localparam int unsigned PhaseW  = 2;

  // command codes, also used as the running command kind
  localparam logic [ActionW-1:0] KIND_IDLE  = 3'd0;
  localparam logic [ActionW-1:0] KIND_START = 3'd1;
  localparam logic [ActionW-1:0] KIND_STOP  = 3'd2;
  localparam logic [ActionW-1:0] KIND_WRITE = 3'd3;
  localparam logic [ActionW-1:0] KIND_READ  = 3'd4;

  localparam logic [CountW-1:0] BITS_PER_BYTE = 4'd8;

  typedef struct packed {
    logic [ActionW-1:0] action;
    logic [ByteW-1:0]   write_byte;
    logic               sda_level;
  } item_t;

  typedef struct packed {
    logic             scl_level;
    logic             sda_pull_low;
    logic             busy_res;
    logic             done_res;
    logic [ByteW-1:0] read_byte;
    logic             read_valid;
  } res_t;

endpackage

`default_nettype wire

/* sv/sccb_ifs.sv */
// ----------------------------------------------------------------------------
// sccb channel interfaces
// Valid/ready channels for tick items and per-tick line results.
// ----------------------------------------------------------------------------
`default_nettype none

interface sccb_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] write_byte;
  logic       sda_level;

  modport source (output valid, action, write_byte, sda_level, input ready);
  modport sink   (input valid, action, write_byte, sda_level, output ready);
endinterface

interface sccb_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_pull_low;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_byte;
  logic       read_valid;

  modport source (output valid, scl_level, sda_pull_low, busy_res, done_res,
                  read_byte, read_valid, input ready);
  modport sink   (input valid, scl_level, sda_pull_low, busy_res, done_res,
                  read_byte, read_valid, output ready);
endinterface

`default_nettype wire

/* sv/sccb_seq.sv */
// ----------------------------------------------------------------------------
// sccb_seq
// Sequencer state and per-tick step logic: command kind, phase, bit count,
// shift register and the SCL / SDA line registers.
// ----------------------------------------------------------------------------
`default_nettype none

module sccb_seq
  import sccb_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        step_i,
  input  wire item_t item_i,
  output res_t       res_o
);

  logic [ActionW-1:0] kind_q, kind_d;
  logic [CountW-1:0]  cnt_q, cnt_d;
  logic [PhaseW-1:0]  phase_q, phase_d;
  logic [ByteW-1:0]   shift_q, shift_d;
  logic               scl_q, scl_d;
  logic               sdl_q, sdl_d;

  // true when the tick runs with no command at all
  function automatic logic kind_d_idle_check(input logic [ActionW-1:0] cur,
                                             input logic [ActionW-1:0] act);
    kind_d_idle_check = (cur == KIND_IDLE) &&
                        !(act == KIND_START || act == KIND_STOP ||
                          act == KIND_WRITE || act == KIND_READ);
  endfunction

  always_comb begin
    logic [ActionW-1:0] kind;
    logic [CountW-1:0]  cnt;
    logic [PhaseW-1:0]  phase;
    logic [ByteW-1:0]   shift;
    logic               scl;
    logic               sdl;
    logic               done;
    logic               rvalid;
    logic [ByteW-1:0]   rbyte;
    logic               after_scl;
    logic               after_sdl;
    logic [ByteW-1:0]   after_shift;

    kind   = kind_q;
    cnt    = cnt_q;
    phase  = phase_q;
    shift  = shift_q;
    scl    = scl_q;
    sdl    = sdl_q;
    done   = 1'b0;
    rvalid = 1'b0;
    rbyte  = '0;

    // take a new command only when idle
    if (kind_q == KIND_IDLE &&
        (item_i.action == KIND_START || item_i.action == KIND_STOP ||
         item_i.action == KIND_WRITE || item_i.action == KIND_READ)) begin
      kind  = item_i.action;
      cnt   = '0;
      phase = '0;
      shift = (item_i.action == KIND_WRITE) ? item_i.write_byte : '0;
    end

    // line changes ahead of this interval
    case (kind)
      KIND_START: begin
        if (phase == 2'd0) begin
          sdl = 1'b0;
          scl = 1'b1;
        end else if (phase == 2'd1) begin
          sdl = 1'b1;
        end else begin
          scl  = 1'b0;
          done = 1'b1;
        end
      end
      KIND_STOP: begin
        if (phase == 2'd0) begin
          sdl = 1'b1;
          scl = 1'b0;
        end else begin
          scl  = 1'b1;
          done = 1'b1;
        end
      end
      KIND_WRITE: begin
        if (cnt < BITS_PER_BYTE) begin
          if (phase == 2'd0) sdl = ~shift[ByteW-1];
          else if (phase == 2'd1) scl = 1'b1;
          else scl = 1'b0;
        end else begin
          if (phase == 2'd0) begin
            sdl = 1'b0;
          end else begin
            scl  = 1'b1;
            done = 1'b1;
          end
        end
      end
      KIND_READ: begin
        if (phase == 2'd0) begin
          if (cnt != '0) shift = {shift[ByteW-2:0], item_i.sda_level};
          scl = 1'b0;
          sdl = 1'b0;
        end else begin
          scl = 1'b1;
          if (cnt >= BITS_PER_BYTE) begin
            done   = 1'b1;
            rvalid = 1'b1;
            rbyte  = shift;
          end
        end
      end
      default: ;
    endcase

    after_scl   = scl;
    after_sdl   = sdl;
    after_shift = shift;

    // advance and post-interval changes
    case (kind)
      KIND_START: phase = phase + 2'd1;
      KIND_STOP: begin
        if (done) after_sdl = 1'b0;
        phase = phase + 2'd1;
      end
      KIND_WRITE: begin
        if (cnt < BITS_PER_BYTE) begin
          if (phase >= 2'd2) begin
            after_shift = {shift[ByteW-2:0], 1'b0};
            phase       = '0;
            cnt         = cnt + 4'd1;
          end else begin
            phase = phase + 2'd1;
          end
        end else begin
          if (done) after_scl = 1'b0;
          phase = phase + 2'd1;
        end
      end
      KIND_READ: begin
        if (done) after_scl = 1'b0;
        if (phase >= 2'd1) begin
          phase = '0;
          cnt   = cnt + 4'd1;
        end else begin
          phase = 2'd1;
        end
      end
      default: ;
    endcase

    if (done) begin
      kind  = KIND_IDLE;
      cnt   = '0;
      phase = '0;
    end

    res_o.scl_level    = scl;
    res_o.sda_pull_low = sdl;
    res_o.busy_res     = (kind_d_idle_check(kind_q, item_i.action)) ? 1'b0 : ~done;
    res_o.done_res     = done;
    res_o.read_byte    = rbyte;
    res_o.read_valid   = rvalid;

    kind_d  = kind;
    cnt_d   = cnt;
    phase_d = phase;
    shift_d = after_shift;
    scl_d   = after_scl;
    sdl_d   = after_sdl;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q  <= KIND_IDLE;
      cnt_q   <= '0;
      phase_q <= '0;
      shift_q <= '0;
      scl_q   <= 1'b1;
      sdl_q   <= 1'b0;
    end else if (step_i) begin
      kind_q  <= kind_d;
      cnt_q   <= cnt_d;
      phase_q <= phase_d;
      shift_q <= shift_d;
      scl_q   <= scl_d;
      sdl_q   <= sdl_d;
    end
  end

endmodule

`default_nettype wire

/* sv/sccb_bit_level_master_core.sv */
// ----------------------------------------------------------------------------
// sccb_bit_level_master_core
// Two-wire SCCB master sequencer driven one half-bit tick per input beat.
// ----------------------------------------------------------------------------
// usage:
//   in_chan carries one beat per half-bit delay tick: an optional command
//   (start, stop, write byte, read byte), the byte to send and the sampled
//   SDA level. out_chan returns one beat per tick with the SCL level, the
//   SDA pull-low, busy, done and, at the end of a read, the read byte.
//   start takes 3 ticks, stop 2, a write 26, a read 18; commands that arrive
//   while a sequence runs are ignored.
// pipeline and throughput:
//   a beat is held in an input register and stepped through the sequencer
//   into the result register, which offers its result on out_chan. one beat
//   is accepted per cycle, sustained, while out_chan is ready.
// reset:
//   the sequencer goes idle with SCL high and SDA released; both registers
//   are empty.
// stall:
//   while out_chan is not ready the result register holds its beat; one
//   more beat is taken into the input register, then in_chan.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module sccb_bit_level_master_core
  import sccb_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  sccb_in_if.sink     in_chan,
  sccb_out_if.source  out_chan
);

  logic  in_vld_q;
  item_t in_item_q;
  logic  out_vld_q;
  res_t  out_res_q;
  res_t  step_res;
  logic  advance;
  logic  in_take;

  assign advance        = in_vld_q && (!out_vld_q || out_chan.ready);
  assign in_chan.ready  = !in_vld_q || advance;
  assign in_take        = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_chan.ready) begin
      in_vld_q <= in_chan.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q.action     <= in_chan.action;
      in_item_q.write_byte <= in_chan.write_byte;
      in_item_q.sda_level  <= in_chan.sda_level;
    end
  end

  sccb_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (in_item_q),
    .res_o  (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_chan.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) out_res_q <= step_res;
  end

  assign out_chan.valid        = out_vld_q;
  assign out_chan.scl_level    = out_res_q.scl_level;
  assign out_chan.sda_pull_low = out_res_q.sda_pull_low;
  assign out_chan.busy_res     = out_res_q.busy_res;
  assign out_chan.done_res     = out_res_q.done_res;
  assign out_chan.read_byte    = out_res_q.read_byte;
  assign out_chan.read_valid   = out_res_q.read_valid;

endmodule

`default_nettype wire
